[design/ttcw_pkg.sv]
// ttcw_pkg: types, character codes, register indexes and reset values
// for the text terminal character writer. No dependencies.
`default_nettype none

package ttcw_pkg;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TILDE = 8'd126;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_UP    = 8'h57;   // 'W'
    localparam logic [7:0] CH_LEFT  = 8'h41;   // 'A'
    localparam logic [7:0] CH_RIGHT = 8'h44;   // 'D'
    localparam logic [7:0] CH_DOWN  = 8'h53;   // 'S'
    localparam logic [3:0] TAB_STEP = 4'd4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLUMNS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_LINES      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTRIBUTE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_CELL     = 2'd3;

    localparam logic [7:0]  RST_COLUMNS = 8'd80;
    localparam logic [6:0]  RST_LINES   = 7'd25;
    localparam logic [7:0]  RST_ATTR    = 8'h07;
    localparam logic [15:0] RST_BLANK   = 16'd1824;

    typedef struct packed {
        logic [8:0]  cols;
        logic [7:0]  lines;
        logic [7:0]  attr;
        logic [15:0] blank;
    } geom_t;

    typedef struct packed {
        logic        cell_write;
        logic [12:0] cell_index;
        logic [15:0] cell_word;
        logic [7:0]  cursor_column;
        logic [5:0]  cursor_line;
        logic [12:0] cursor_index;
    } result_t;

    function automatic logic [8:0] clamp_cols(input logic [7:0] raw, input int unsigned max);
        logic [8:0] lim;
        lim = 9'(max);
        if (raw == 8'd0)
            return 9'd1;
        else if ({1'b0, raw} > lim)
            return lim;
        else
            return {1'b0, raw};
    endfunction

    function automatic logic [7:0] clamp_lines(input logic [6:0] raw, input int unsigned max);
        logic [7:0] lim;
        lim = 8'(max);
        if (raw == 7'd0)
            return 8'd1;
        else if ({1'b0, raw} > lim)
            return lim;
        else
            return {1'b0, raw};
    endfunction

endpackage

`default_nettype wire

[design/ttcw_if.sv]
// ttcw_if: character, result and register write channels.
// Depends on ttcw_pkg for the result payload and register widths.
`default_nettype none

interface ttcw_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface ttcw_res_if;
    logic              valid;
    logic              ready;
    ttcw_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ttcw_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ttcw_pkg::CFG_IDX_W-1:0]    index;
    logic [ttcw_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/ttcw_cfg.sv]
// ttcw_cfg: geometry and attribute registers, geometry held clamped.
// Depends on ttcw_pkg.
`default_nettype none

module ttcw_cfg #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_LINES   = 64
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             wr_valid,
    output logic                                  wr_ready,
    input  wire logic [ttcw_pkg::CFG_IDX_W-1:0]   wr_index,
    input  wire logic [ttcw_pkg::CFG_DATA_W-1:0]  wr_data,
    output ttcw_pkg::geom_t                       geom
);
    import ttcw_pkg::*;

    logic [8:0]  cols_reg;
    logic [7:0]  lines_reg;
    logic [7:0]  attr_reg;
    logic [15:0] blank_reg;

    assign wr_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg  <= clamp_cols(RST_COLUMNS, MAX_COLUMNS);
            lines_reg <= clamp_lines(RST_LINES, MAX_LINES);
            attr_reg  <= RST_ATTR;
            blank_reg <= RST_BLANK;
        end
        else if (wr_valid)
        begin
            unique case (wr_index)
                CFG_NUM_COLUMNS:    cols_reg  <= clamp_cols(wr_data[7:0], MAX_COLUMNS);
                CFG_NUM_LINES:      lines_reg <= clamp_lines(wr_data[6:0], MAX_LINES);
                CFG_TEXT_ATTRIBUTE: attr_reg  <= wr_data[7:0];
                CFG_BLANK_CELL:     blank_reg <= wr_data;
            endcase
        end
    end

    assign geom = '{cols: cols_reg, lines: lines_reg, attr: attr_reg, blank: blank_reg};

endmodule

`default_nettype wire

[design/ttcw_cursor.sv]
// ttcw_cursor: cursor and escape state, character decode and cell index.
// Depends on ttcw_pkg.
`default_nettype none

module ttcw_cursor #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_LINES   = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        ch,
    input  wire ttcw_pkg::geom_t   geom,
    output ttcw_pkg::result_t      result
);
    import ttcw_pkg::*;

    localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
    localparam int LINE_W = $clog2(MAX_LINES);

    logic [COL_W-1:0]  column_reg, column_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              escape_pending_reg, escape_pending_next;

    logic [9:0]  col_x, cols_x, col_n_x, tab_x, tab_wrap_x;
    logic [7:0]  line_x, line_n_x, down_x;
    logic        wr, prt;
    logic [15:0] word;
    logic [15:0] prod;
    logic [12:0] cur_idx;

    always_comb
    begin
        col_x      = 10'(column_reg);
        cols_x     = 10'(geom.cols);
        line_x     = 8'(line_reg);
        down_x     = (line_x + 8'd1 < geom.lines) ? line_x + 8'd1 : line_x;
        tab_x      = col_x + 10'(TAB_STEP);
        tab_wrap_x = tab_x - cols_x;

        col_n_x             = col_x;
        line_n_x            = line_x;
        escape_pending_next = 1'b0;
        wr                  = 1'b0;
        prt                 = 1'b0;
        word                = '0;

        if (escape_pending_reg)
        begin
            unique case (ch)
                CH_UP:
                    if (line_x != 8'd0)
                        line_n_x = line_x - 8'd1;
                CH_LEFT:
                    if (col_x != 10'd0)
                        col_n_x = col_x - 10'd1;
                CH_RIGHT:
                    if (col_x + 10'd1 < cols_x)
                        col_n_x = col_x + 10'd1;
                CH_DOWN:
                    line_n_x = down_x;
                default: ;
            endcase
        end
        else
        begin
            unique case (ch) inside
                CH_ESC:
                    escape_pending_next = 1'b1;
                [CH_SPACE:CH_TILDE]:
                begin
                    // wrap before the write when at or past the margin
                    if (col_x >= cols_x)
                    begin
                        col_n_x  = 10'd1;
                        line_n_x = down_x;
                    end
                    else
                        col_n_x = col_x + 10'd1;
                    wr   = 1'b1;
                    prt  = 1'b1;
                    word = {geom.attr, ch};
                end
                CH_BS, CH_DEL:
                    if (col_x != 10'd0)
                    begin
                        col_n_x = col_x - 10'd1;
                        wr      = 1'b1;
                        word    = geom.blank;
                    end
                CH_TAB:
                    if (tab_x > cols_x)
                    begin
                        col_n_x  = (tab_wrap_x > cols_x) ? 10'd0 : tab_wrap_x;
                        line_n_x = down_x;
                    end
                    else
                        col_n_x = tab_x;
                CH_LF:
                begin
                    col_n_x  = 10'd0;
                    line_n_x = down_x;
                end
                CH_CR:
                    col_n_x = 10'd0;
                default: ;
            endcase
        end

        column_next = COL_W'(col_n_x);
        line_next   = LINE_W'(line_n_x);

        prod    = 16'(line_n_x) * 16'(geom.cols) + 16'(col_n_x);
        cur_idx = prod[12:0];

        // a printed cell sits one left of the cursor that follows it
        result.cell_write    = wr;
        result.cell_index    = wr ? (prt ? cur_idx - 13'd1 : cur_idx) : 13'd0;
        result.cell_word     = word;
        result.cursor_column = 8'(col_n_x);
        result.cursor_line   = 6'(line_n_x);
        result.cursor_index  = cur_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg         <= '0;
            line_reg           <= '0;
            escape_pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            column_reg         <= column_next;
            line_reg           <= line_next;
            escape_pending_reg <= escape_pending_next;
        end
    end

endmodule

`default_nettype wire

[design/ttcw_out_buf.sv]
// ttcw_out_buf: result register with a skid entry behind it.
// Depends on ttcw_pkg.
`default_nettype none

module ttcw_out_buf (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire ttcw_pkg::result_t  din,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ttcw_pkg::result_t       dout
);
    import ttcw_pkg::*;

    logic    main_valid_reg, skid_valid_reg;
    result_t main_data_reg, skid_data_reg;
    logic    load;

    assign load      = !main_valid_reg || out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign dout      = main_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            main_data_reg <= skid_valid_reg ? skid_data_reg : din;
        if (push && !load)
            skid_data_reg <= din;
    end

endmodule

`default_nettype wire

[design/text_terminal_char_writer_top.sv]
// text_terminal_char_writer_top: cursor engine of a text-mode console.
// Depends on ttcw_pkg, ttcw_if, ttcw_cfg, ttcw_cursor, ttcw_out_buf.
// A result is registered, into the skid entry while the output stalls.
// Throughput: one character per cycle while the skid entry is empty, with a
// combinational cursor update and one index multiply; a two-deep buffer absorbs stalls.
// Reset: cursor at row 0 column 0, no escape, registers at their defaults.
`default_nettype none

module text_terminal_char_writer_top #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_LINES   = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    ttcw_char_if.sink         chars,
    ttcw_res_if.source        results,
    ttcw_cfg_if.sink          cfg
);
    import ttcw_pkg::*;

    geom_t   geom;
    result_t step_res;
    logic    in_ready;
    logic    accept;

    assign chars.ready = in_ready;
    assign accept      = chars.valid && in_ready;

    ttcw_cfg #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_LINES   (MAX_LINES)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_ready (cfg.ready),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .geom     (geom)
    );

    ttcw_cursor #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_LINES   (MAX_LINES)
    ) u_cursor (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .ch     (chars.ch),
        .geom   (geom),
        .result (step_res)
    );

    ttcw_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .din       (step_res),
        .in_ready  (in_ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .dout      (results.data)
    );

endmodule

`default_nettype wire

[design/ttcw_checker.sv]
// ttcw_checker: port-level checks on the character writer, bound to the top.
// Depends on ttcw_pkg and text_terminal_char_writer_top.
`default_nettype none

module ttcw_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire ttcw_pkg::result_t out_data
);
    import ttcw_pkg::*;

    // every accepted beat is followed in the next cycle by a valid output
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted beat without result");

    // back-pressure only ever comes from a full result buffer
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.cell_write |->
            out_data.cell_index == 13'd0 && out_data.cell_word == 16'd0)
        else $error("cell fields set without a write");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

endmodule

bind text_terminal_char_writer_top ttcw_checker u_ttcw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chars.valid),
    .in_ready  (chars.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (results.data)
);

`default_nettype wire

[tb/sv/tb_text_terminal_char_writer_top.sv]
// Self-checking testbench for text_terminal_char_writer_top: drives character
// beats and register writes, predicts each result beat and compares it field by field.
// Depends on ttcw_pkg, ttcw_if and the design sources.
module tb_text_terminal_char_writer_top;
    import ttcw_pkg::*;

    localparam int COL_LIMIT  = 128;
    localparam int LINE_LIMIT = 64;

    logic clk;
    logic rst_n;

    ttcw_char_if chars_if ();
    ttcw_res_if  res_if ();
    ttcw_cfg_if  cfg_if ();

    text_terminal_char_writer_top #(
        .MAX_COLUMNS (COL_LIMIT),
        .MAX_LINES   (LINE_LIMIT)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (res_if),
        .cfg     (cfg_if)
    );

    // shadow registers and cursor state
    logic [7:0]  cols_raw;
    logic [6:0]  lines_raw;
    logic [7:0]  attr_reg;
    logic [15:0] blank_reg;
    int          cur_col;
    int          cur_line;
    bit          esc_armed;

    result_t expected_cells[$];
    int      errors;
    bit      calm;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic int screen_cols();
        if (cols_raw == 8'd0)
            return 1;
        if (int'(cols_raw) > COL_LIMIT)
            return COL_LIMIT;
        return int'(cols_raw);
    endfunction

    function automatic int screen_lines();
        if (lines_raw == 7'd0)
            return 1;
        if (int'(lines_raw) > LINE_LIMIT)
            return LINE_LIMIT;
        return int'(lines_raw);
    endfunction

    function automatic void line_down();
        if (cur_line + 1 < screen_lines())
            cur_line++;
    endfunction

    function automatic result_t advance_cursor(input logic [7:0] c);
        result_t r;
        int      ncols;
        ncols = screen_cols();
        r = '0;
        if (esc_armed)
        begin
            esc_armed = 1'b0;
            case (c)
                CH_UP:    if (cur_line > 0) cur_line--;
                CH_LEFT:  if (cur_col > 0) cur_col--;
                CH_RIGHT: if (cur_col + 1 < ncols) cur_col++;
                CH_DOWN:  line_down();
                default:  ;
            endcase
        end
        else if (c == CH_ESC)
            esc_armed = 1'b1;
        else if (c >= CH_SPACE && c <= CH_TILDE)
        begin
            if (cur_col >= ncols)
            begin
                cur_col = 0;
                line_down();
            end
            r.cell_write = 1'b1;
            r.cell_index = 13'(cur_line * ncols + cur_col);
            r.cell_word  = {attr_reg, c};
            cur_col++;
        end
        else if (c == CH_BS || c == CH_DEL)
        begin
            if (cur_col > 0)
            begin
                cur_col--;
                r.cell_write = 1'b1;
                r.cell_index = 13'(cur_line * ncols + cur_col);
                r.cell_word  = blank_reg;
            end
        end
        else if (c == CH_TAB)
        begin
            cur_col += int'(TAB_STEP);
            if (cur_col > ncols)
            begin
                cur_col -= ncols;
                if (cur_col > ncols)
                    cur_col = 0;
                line_down();
            end
        end
        else if (c == CH_LF)
        begin
            cur_col = 0;
            line_down();
        end
        else if (c == CH_CR)
            cur_col = 0;
        r.cursor_column = 8'(cur_col);
        r.cursor_line   = 6'(cur_line);
        r.cursor_index  = 13'(cur_line * ncols + cur_col);
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            errors++;
        end
    endfunction

    // result sink
    always @(negedge clk)
        res_if.ready = calm ? 1'b1 : ($urandom_range(0, 99) >= 26);

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got = res_if.data;
            if (expected_cells.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                want = expected_cells.pop_front();
                check_field("cell_write", want.cell_write, got.cell_write);
                check_field("cell_index", want.cell_index, got.cell_index);
                check_field("cell_word", want.cell_word, got.cell_word);
                check_field("cursor_column", want.cursor_column, got.cursor_column);
                check_field("cursor_line", want.cursor_line, got.cursor_line);
                check_field("cursor_index", want.cursor_index, got.cursor_index);
            end
        end
    end

    task automatic send_char(input logic [7:0] c);
        chars_if.valid = 1'b0;
        while (!calm && $urandom_range(0, 99) < 26)
            @(negedge clk);
        chars_if.valid = 1'b1;
        chars_if.ch    = c;
        do
            @(posedge clk);
        while (!chars_if.ready);
        expected_cells.push_back(advance_cursor(c));
        @(negedge clk);
        chars_if.valid = 1'b0;
    endtask

    task automatic send_escape(input logic [7:0] c);
        send_char(CH_ESC);
        send_char(c);
    endtask

    task automatic wait_drained();
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        wait_drained();
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        case (idx)
            CFG_NUM_COLUMNS:    cols_raw  = value[7:0];
            CFG_NUM_LINES:      lines_raw = value[6:0];
            CFG_TEXT_ATTRIBUTE: attr_reg  = value[7:0];
            CFG_BLANK_CELL:     blank_reg = value;
            default:            ;
        endcase
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic send_random_token();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            send_char(8'($urandom_range(32, 126)));
        else if (pick < 50)
            send_char(CH_BS);
        else if (pick < 55)
            send_char(CH_DEL);
        else if (pick < 63)
            send_char(CH_TAB);
        else if (pick < 70)
            send_char(CH_LF);
        else if (pick < 74)
            send_char(CH_CR);
        else if (pick < 88)
        begin
            case ($urandom_range(0, 4))
                0:       send_escape(CH_UP);
                1:       send_escape(CH_LEFT);
                2:       send_escape(CH_RIGHT);
                3:       send_escape(CH_DOWN);
                default: send_escape(8'($urandom_range(0, 255)));
            endcase
        end
        else
            send_char(8'($urandom_range(0, 255)));
    endtask

    task automatic test_reset_defaults();
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h80);
        send_char(8'd31);
        send_char(CH_BS);
        send_char(CH_SPACE);
        send_char(CH_TILDE);
        send_char(CH_DEL);
        send_char(CH_BS);
        send_char(CH_BS);
        send_char(CH_TAB);
        send_char(CH_CR);
        send_char(CH_LF);
        send_escape(CH_RIGHT);
        send_escape(CH_DOWN);
        send_escape(CH_LEFT);
        send_escape(CH_UP);
        send_escape(CH_ESC);
        send_char(8'h78);
    endtask

    task automatic test_small_screen();
        string text;
        text = "abcdefg";
        write_reg(CFG_NUM_COLUMNS, 16'd3);
        write_reg(CFG_NUM_LINES, 16'd2);
        write_reg(CFG_TEXT_ATTRIBUTE, 16'h1E);
        write_reg(CFG_BLANK_CELL, 16'h1E20);
        foreach (text[i])
            send_char(text[i]);
        send_escape(CH_DOWN);
        send_char(CH_TAB);
        send_escape(CH_UP);
        send_escape(CH_UP);
        send_escape(CH_RIGHT);
        send_escape(CH_RIGHT);
        send_escape(CH_RIGHT);
        send_char(CH_CR);
        send_escape(CH_LEFT);
        send_char(CH_DEL);
        send_char(CH_LF);
        send_char(CH_LF);
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_NUM_COLUMNS, 16'd0);
        write_reg(CFG_NUM_LINES, 16'd0);
        write_reg(CFG_TEXT_ATTRIBUTE, 16'h00);
        write_reg(CFG_BLANK_CELL, 16'h0000);
        repeat (12) send_random_token();
        write_reg(CFG_NUM_COLUMNS, 16'd1);
        write_reg(CFG_NUM_LINES, 16'd1);
        repeat (12) send_random_token();
        write_reg(CFG_NUM_COLUMNS, 16'd255);
        write_reg(CFG_NUM_LINES, 16'd127);
        write_reg(CFG_TEXT_ATTRIBUTE, 16'hFF);
        write_reg(CFG_BLANK_CELL, 16'hFFFF);
        send_char(CH_CR);
        repeat (LINE_LIMIT) send_char(CH_LF);
        // cursor one past the last cell of the largest screen
        repeat (COL_LIMIT / 4) send_char(CH_TAB);
        send_char(CH_BS);
        send_char("z");
        send_char("y");
        write_reg(CFG_NUM_COLUMNS, 16'd128);
        write_reg(CFG_NUM_LINES, 16'd64);
        send_char(CH_TAB);
        send_escape(CH_DOWN);
        send_char("q");
    endtask

    task automatic test_narrowed_geometry();
        write_reg(CFG_NUM_COLUMNS, 16'd100);
        write_reg(CFG_NUM_LINES, 16'd40);
        repeat (20) send_char(CH_LF);
        repeat (23) send_char(CH_TAB);
        write_reg(CFG_NUM_COLUMNS, 16'd5);
        write_reg(CFG_NUM_LINES, 16'd3);
        send_char(CH_BS);
        send_escape(CH_RIGHT);
        send_escape(CH_DOWN);
        send_char(CH_TAB);
        repeat (3) send_char(CH_TAB);
        write_reg(CFG_NUM_COLUMNS, 16'd2);
        send_char(CH_TAB);
        send_char("k");
        send_escape(CH_UP);
    endtask

    task automatic test_random_traffic();
        int picks;
        for (int phase = 0; phase < 8; phase++)
        begin
            picks = $urandom_range(0, 9);
            if (picks < 6)
                write_reg(CFG_NUM_COLUMNS, 16'($urandom_range(1, 12)));
            else if (picks < 8)
                write_reg(CFG_NUM_COLUMNS, 16'($urandom_range(13, 128)));
            else
                write_reg(CFG_NUM_COLUMNS, 16'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_NUM_LINES, 16'($urandom_range(1, 6)));
            else
                write_reg(CFG_NUM_LINES, 16'($urandom_range(0, 127)));
            write_reg(CFG_TEXT_ATTRIBUTE, 16'($urandom_range(0, 255)));
            write_reg(CFG_BLANK_CELL, 16'($urandom_range(0, 65535)));
            calm = (phase == 3);
            for (int n = 0; n < 80; n++)
            begin
                send_random_token();
                if (n == 40)
                    wait_drained();
            end
            calm = 1'b0;
        end
    endtask

    initial
    begin
        #2000000;
        $display("tb_text_terminal_char_writer_top NOT OK");
        $finish;
    end

    initial
    begin
        errors          = 0;
        calm            = 1'b0;
        rst_n           = 1'b0;
        chars_if.valid  = 1'b0;
        chars_if.ch     = 8'd0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = CFG_NUM_COLUMNS;
        cfg_if.data     = 16'd0;
        res_if.ready    = 1'b0;
        cols_raw        = RST_COLUMNS;
        lines_raw       = RST_LINES;
        attr_reg        = RST_ATTR;
        blank_reg       = RST_BLANK;
        cur_col         = 0;
        cur_line        = 0;
        esc_armed       = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_small_screen();
        test_register_extremes();
        test_narrowed_geometry();
        test_random_traffic();

        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tb_text_terminal_char_writer_top OK");
        else
            $display("tb_text_terminal_char_writer_top NOT OK");
        $finish;
    end
endmodule

[filelist.f]
design/ttcw_pkg.sv
design/ttcw_if.sv
design/ttcw_cfg.sv
design/ttcw_cursor.sv
design/ttcw_out_buf.sv
design/text_terminal_char_writer_top.sv
design/ttcw_checker.sv
tb/sv/tb_text_terminal_char_writer_top.sv
